FILE: hdl/block_bitmap_piece_picker_core_defines.svh
// ---------------------------------------------------------------------------
// block bitmap piece picker: assertion macros
// shared property wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_PIECE_PICKER_CORE_DEFINES_SVH
`define BLOCK_BITMAP_PIECE_PICKER_CORE_DEFINES_SVH

// implication checked out of reset
`define BBPP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bbpp port check failed");

// next-cycle implication that also holds during reset
`define BBPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("bbpp port check failed");

`endif

FILE: hdl/bbpp_pkg.sv
// ---------------------------------------------------------------------------
// bbpp_pkg
// shared types, constants and helpers of the block bitmap piece picker
// ---------------------------------------------------------------------------
package bbpp_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = BLK_W + 1;
    localparam int WORD_W     = (MAX_BLOCKS < 64) ? MAX_BLOCKS : 64;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int ROWS       = MAX_BLOCKS / WORD_W;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BSZ_W      = 25;
    localparam int MSS_W      = 31;
    localparam int CFG_W      = 31;
    localparam int CIDX_W     = 2;
    localparam int OP_W       = 4;
    localparam int ACC_W      = CNT_W + BSZ_W;
    localparam int QDEPTH     = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_SET_HAVE   = 4'd0;
    localparam logic [OP_W-1:0] OP_CLR_HAVE   = 4'd1;
    localparam logic [OP_W-1:0] OP_SET_USE    = 4'd2;
    localparam logic [OP_W-1:0] OP_CLR_USE    = 4'd3;
    localparam logic [OP_W-1:0] OP_SET_FILTER = 4'd4;
    localparam logic [OP_W-1:0] OP_CLR_FILTER = 4'd5;
    localparam logic [OP_W-1:0] OP_SET_IGNORE = 4'd6;
    localparam logic [OP_W-1:0] OP_CLR_IGNORE = 4'd7;
    localparam logic [OP_W-1:0] OP_FIRST      = 4'd8;
    localparam logic [OP_W-1:0] OP_SPARSE     = 4'd9;
    localparam logic [OP_W-1:0] OP_INORDER    = 4'd10;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_BLOCK_COUNT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MIN_SPLIT   = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_FILTER_ON   = 2'd3;

    typedef enum logic [2:0] {
        K_NONE    = 3'd0,
        K_BIT     = 3'd1,
        K_FIRST   = 3'd2,
        K_SPARSE  = 3'd3,
        K_INORDER = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        MAP_HAVE   = 2'd0,
        MAP_USE    = 2'd1,
        MAP_FILTER = 2'd2,
        MAP_IGNORE = 2'd3
    } t_map;

    typedef struct packed {
        logic [CNT_W-1:0] block_count;
        logic [BSZ_W-1:0] block_size;
        logic [MSS_W-1:0] min_split;
        logic             filter_on;
    } t_cfg;

    typedef struct packed {
        t_kind            kind;
        t_map             map;
        logic             set_val;
        logic             in_range;
        logic [BLK_W-1:0] idx;
        logic [CNT_W-1:0] end_idx;
    } t_cmd;

    // block count clamped to the map depth
    function automatic logic [CNT_W-1:0] nblocks(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'(MAX_BLOCKS);
        return (cnt > lim) ? lim : cnt;
    endfunction

endpackage

FILE: hdl/bbpp_ram.sv
// ---------------------------------------------------------------------------
// bbpp_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module bbpp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/bbpp_front.sv
// ---------------------------------------------------------------------------
// bbpp_front
// classifies an incoming beat into a command for the back end
// ---------------------------------------------------------------------------
module bbpp_front (
    input  logic [bbpp_pkg::OP_W-1:0]  i_opcode,
    input  logic [bbpp_pkg::BLK_W-1:0] i_index,
    input  logic [bbpp_pkg::CNT_W-1:0] i_end_index,
    input  bbpp_pkg::t_cfg             i_cfg,
    output bbpp_pkg::t_cmd             o_cmd
);
    import bbpp_pkg::*;

    logic [CNT_W-1:0] nb;

    always_comb begin
        nb              = nblocks(i_cfg.block_count);
        o_cmd.idx       = i_index;
        o_cmd.end_idx   = i_end_index;
        o_cmd.in_range  = ({1'b0, i_index} < nb);
        o_cmd.set_val   = ~i_opcode[0];
        o_cmd.map       = t_map'(i_opcode[2:1]);
        unique case (i_opcode) inside
            [OP_SET_HAVE:OP_CLR_IGNORE]: o_cmd.kind = K_BIT;
            OP_FIRST:                    o_cmd.kind = K_FIRST;
            OP_SPARSE:                   o_cmd.kind = K_SPARSE;
            OP_INORDER:                  o_cmd.kind = K_INORDER;
            default:                     o_cmd.kind = K_NONE;
        endcase
    end
endmodule

FILE: hdl/bbpp_queue.sv
// ---------------------------------------------------------------------------
// bbpp_queue
// short command queue between front and back end
// ---------------------------------------------------------------------------
module bbpp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bbpp_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output bbpp_pkg::t_cmd o_cmd
);
    import bbpp_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    t_cmd               r_slot [QDEPTH];
    logic [PTR_W-1:0]   r_wptr, r_rptr;
    logic [PTR_W:0]     r_cnt;
    logic [PTR_W-1:0]   n_wptr, n_rptr;
    logic [PTR_W:0]     n_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (PTR_W+1)'(QDEPTH));
    assign o_cmd   = r_slot[r_rptr];
endmodule

FILE: hdl/bbpp_back.sv
// ---------------------------------------------------------------------------
// bbpp_back
// executes commands: map updates, block scan, picks and missing count
// ---------------------------------------------------------------------------
module bbpp_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bbpp_pkg::t_cfg             i_cfg,
    input  logic                       i_cmd_valid,
    input  bbpp_pkg::t_cmd             i_cmd,
    output logic                       o_cmd_pop,
    output logic                       o_clearing,
    output logic                       o_done,
    output logic                       o_ok,
    output logic                       o_found,
    output logic [bbpp_pkg::BLK_W-1:0] o_block_index,
    output logic [bbpp_pkg::CNT_W-1:0] o_missing_count
);
    import bbpp_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_RMW_RD = 9'b000000100,
        S_RMW_WR = 9'b000001000,
        S_RD     = 9'b000010000,
        S_BIT    = 9'b000100000,
        S_FIN    = 9'b001000000,
        S_MUL    = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic [CNT_W-1:0]   r_miss, n_miss;
    logic               r_found, n_found;
    logic [BLK_W-1:0]   r_blk, n_blk;
    logic               r_prev_busy, n_prev_busy;
    logic               r_prev_use, n_prev_use;
    logic               r_in_run, n_in_run;
    logic [CNT_W-1:0]   r_rs, n_rs;
    logic               r_rs_adj, n_rs_adj;
    logic               r_rs_pd, n_rs_pd;
    logic [CNT_W-1:0]   r_bs, n_bs;
    logic [CNT_W-1:0]   r_blen, n_blen;
    logic               r_bpd, n_bpd;
    logic               r_srch, n_srch;
    logic               r_walk, n_walk;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [ACC_W-1:0]   r_prod, n_prod;
    logic               r_done, n_done;
    logic               r_ok, n_ok;
    logic               r_ofound, n_ofound;
    logic [BLK_W-1:0]   r_oblk, n_oblk;
    logic [CNT_W-1:0]   r_omiss, n_omiss;

    // ram ports
    logic [3:0]         we;
    logic               re;
    logic [ROW_W-1:0]   waddr, raddr;
    logic [WORD_W-1:0]  rdata [4];
    logic [WORD_W-1:0]  wdata [4];
    logic [WORD_W-1:0]  mask;

    // scan helpers
    logic [CNT_W-1:0]   nb, last, pos_inc;
    logic [BIT_W-1:0]   bsel;
    logic               b_have, b_use, b_filt, b_ign, b_busy, b_free;
    logic [CNT_W-1:0]   diff, half, s_new, len;
    logic               better;
    logic [ACC_W-1:0]   bsz_ext, acc_n, mss_ext;
    logic               sp_found;

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_map
            bbpp_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_ram (
                .i_clk   (i_clk),
                .i_we    (we[g]),
                .i_waddr (waddr),
                .i_wdata (wdata[g]),
                .i_re    (re),
                .i_raddr (raddr),
                .o_rdata (rdata[g])
            );
        end
    endgenerate

    always_comb begin
        nb      = nblocks(i_cfg.block_count);
        last    = (r_cmd.end_idx < nb) ? r_cmd.end_idx : nb;
        pos_inc = r_pos + 1'b1;
        bsel    = r_pos[BIT_W-1:0];
        b_have  = rdata[MAP_HAVE][bsel];
        b_use   = rdata[MAP_USE][bsel];
        b_filt  = rdata[MAP_FILTER][bsel];
        b_ign   = rdata[MAP_IGNORE][bsel];
        b_busy  = b_have | b_use | b_ign | (i_cfg.filter_on & ~b_filt);
        b_free  = ~b_busy;
        bsz_ext = ACC_W'(i_cfg.block_size);
        mss_ext = ACC_W'(i_cfg.min_split);
        acc_n   = r_acc + bsz_ext;

        // closing a free run that ends at the current position
        diff    = r_pos - r_rs;
        half    = diff >> 1;
        s_new   = r_rs_adj ? (r_rs + half) : r_rs;
        len     = r_rs_adj ? (diff - half) : diff;
        better  = (len > r_blen) ||
                  ((len == r_blen) && (r_bs != '0) && (s_new != '0) && !r_bpd && r_rs_pd);

        sp_found = (r_blen != '0) && ((r_bs == '0) || r_bpd || (r_prod >= mss_ext));

        mask = '0;
        mask[r_cmd.idx[BIT_W-1:0]] = 1'b1;
        for (int m = 0; m < 4; m++) begin
            wdata[m] = (r_state == S_CLEAR) ? '0 :
                       (r_cmd.set_val ? (rdata[m] | mask) : (rdata[m] & ~mask));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_miss      = r_miss;
        n_found     = r_found;
        n_blk       = r_blk;
        n_prev_busy = r_prev_busy;
        n_prev_use  = r_prev_use;
        n_in_run    = r_in_run;
        n_rs        = r_rs;
        n_rs_adj    = r_rs_adj;
        n_rs_pd     = r_rs_pd;
        n_bs        = r_bs;
        n_blen      = r_blen;
        n_bpd       = r_bpd;
        n_srch      = r_srch;
        n_walk      = r_walk;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_done      = 1'b0;
        n_ok        = r_ok;
        n_ofound    = r_ofound;
        n_oblk      = r_oblk;
        n_omiss     = r_omiss;
        o_cmd_pop   = 1'b0;
        we          = '0;
        re          = 1'b0;
        waddr       = ROW_W'(r_cmd.idx >> BIT_W);
        raddr       = ROW_W'(r_pos >> BIT_W);

        unique case (r_state)
            S_CLEAR: begin
                we    = '1;
                waddr = ROW_W'(r_pos);
                n_pos = pos_inc;
                if (r_pos == CNT_W'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop   = 1'b1;
                    n_cmd       = i_cmd;
                    n_pos       = '0;
                    n_miss      = '0;
                    n_found     = 1'b0;
                    n_blk       = '0;
                    n_prev_busy = 1'b0;
                    n_prev_use  = 1'b0;
                    n_in_run    = 1'b0;
                    n_bs        = '0;
                    n_blen      = '0;
                    n_bpd       = 1'b0;
                    n_srch      = 1'b0;
                    n_walk      = 1'b0;
                    if (i_cmd.kind == K_BIT && i_cmd.in_range) begin
                        n_state = S_RMW_RD;
                    end else if (nb == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RMW_RD: begin
                re      = 1'b1;
                raddr   = ROW_W'(r_cmd.idx >> BIT_W);
                n_state = S_RMW_WR;
            end
            S_RMW_WR: begin
                we[r_cmd.map] = 1'b1;
                n_state       = S_RD;
            end
            S_RD: begin
                re      = 1'b1;
                n_state = S_BIT;
            end
            S_BIT: begin
                // missing count
                if (!b_have && (!i_cfg.filter_on || b_filt)) begin
                    n_miss = r_miss + 1'b1;
                end
                // free runs for the sparse pick
                if (b_free && !r_in_run) begin
                    n_in_run = 1'b1;
                    n_rs     = r_pos;
                    n_rs_adj = (r_pos != '0) && r_prev_use;
                    n_rs_pd  = (r_pos != '0) && !r_prev_use;
                end else if (b_busy && r_in_run) begin
                    n_in_run = 1'b0;
                    if (better) begin
                        n_bs   = s_new;
                        n_blen = len;
                        n_bpd  = r_rs_pd;
                    end
                end
                // first pick
                if (r_cmd.kind == K_FIRST && !r_found && !b_have && !b_use &&
                    (!i_cfg.filter_on || b_filt)) begin
                    n_found = 1'b1;
                    n_blk   = r_pos[BLK_W-1:0];
                end
                // in-order pick
                if (r_cmd.kind == K_INORDER && !r_found) begin
                    if (r_pos == {1'b0, r_cmd.idx}) begin
                        if (b_free) begin
                            n_found = 1'b1;
                            n_blk   = r_pos[BLK_W-1:0];
                        end else begin
                            n_srch = 1'b1;
                        end
                    end else if (r_walk) begin
                        if (b_free) begin
                            n_acc = acc_n;
                            if (acc_n >= mss_ext) begin
                                n_found = 1'b1;
                                n_blk   = r_pos[BLK_W-1:0];
                            end
                        end else begin
                            n_walk = 1'b0;
                        end
                    end else if (r_srch) begin
                        if (r_pos >= last) begin
                            n_srch = 1'b0;
                        end else if (b_free) begin
                            if ((r_prev_busy && !r_prev_use) || (bsz_ext >= mss_ext)) begin
                                n_found = 1'b1;
                                n_blk   = r_pos[BLK_W-1:0];
                            end else begin
                                n_walk = 1'b1;
                                n_acc  = bsz_ext;
                            end
                        end
                    end
                end
                n_prev_busy = b_busy;
                n_prev_use  = b_use;
                n_pos       = pos_inc;
                if (pos_inc == nb) begin
                    n_state = S_FIN;
                end else if (pos_inc[BIT_W-1:0] == '0) begin
                    n_state = S_RD;
                end
            end
            S_FIN: begin
                if (r_in_run) begin
                    n_in_run = 1'b0;
                    if (better) begin
                        n_bs   = s_new;
                        n_blen = len;
                        n_bpd  = r_rs_pd;
                    end
                end
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = ACC_W'(r_blen) * bsz_ext;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_done  = 1'b1;
                n_ok    = (r_cmd.kind == K_BIT) && r_cmd.in_range;
                n_omiss = r_miss;
                if (r_cmd.kind == K_SPARSE) begin
                    n_ofound = sp_found;
                    n_oblk   = sp_found ? r_bs[BLK_W-1:0] : '0;
                end else if (r_cmd.kind == K_FIRST || r_cmd.kind == K_INORDER) begin
                    n_ofound = r_found;
                    n_oblk   = r_found ? r_blk : '0;
                end else begin
                    n_ofound = 1'b0;
                    n_oblk   = '0;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pos   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_done  <= n_done;
        end
        r_cmd       <= n_cmd;
        r_miss      <= n_miss;
        r_found     <= n_found;
        r_blk       <= n_blk;
        r_prev_busy <= n_prev_busy;
        r_prev_use  <= n_prev_use;
        r_in_run    <= n_in_run;
        r_rs        <= n_rs;
        r_rs_adj    <= n_rs_adj;
        r_rs_pd     <= n_rs_pd;
        r_bs        <= n_bs;
        r_blen      <= n_blen;
        r_bpd       <= n_bpd;
        r_srch      <= n_srch;
        r_walk      <= n_walk;
        r_acc       <= n_acc;
        r_prod      <= n_prod;
        r_ok        <= n_ok;
        r_ofound    <= n_ofound;
        r_oblk      <= n_oblk;
        r_omiss     <= n_omiss;
    end

    assign o_clearing      = (r_state == S_CLEAR);
    assign o_done          = r_done;
    assign o_ok            = r_ok;
    assign o_found         = r_ofound;
    assign o_block_index   = r_oblk;
    assign o_missing_count = r_omiss;
endmodule

FILE: hdl/block_bitmap_piece_picker_core.sv
// ---------------------------------------------------------------------------
// block_bitmap_piece_picker_core
// piece picker over have / in-use / wanted / ignore block bitmaps
// ---------------------------------------------------------------------------
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------
// command   | i_start, o_busy      | i_opcode, i_index, i_end_index
// result    | o_done (strobe)      | o_ok, o_found, o_block_index,
//           |                      | o_missing_count
// config    | i_cfg_we             | i_cfg_index, i_cfg_data
//
// every beat runs one pass over the bitmaps, one block per cycle, held for
// one ram read per 64-block word; a bit update first does a read-modify-write
// of one word
// after reset a clearing pass zeroes the maps; busy stays high through it
// a two-entry queue lets up to two beats wait while one is worked on
// results are strobed for one cycle; the receiver cannot stall them
// ---------------------------------------------------------------------------
module block_bitmap_piece_picker_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [bbpp_pkg::OP_W-1:0]   i_opcode,
    input  logic [bbpp_pkg::BLK_W-1:0]  i_index,
    input  logic [bbpp_pkg::CNT_W-1:0]  i_end_index,
    output logic                        o_done,
    output logic                        o_ok,
    output logic                        o_found,
    output logic [bbpp_pkg::BLK_W-1:0]  o_block_index,
    output logic [bbpp_pkg::CNT_W-1:0]  o_missing_count,
    input  logic                        i_cfg_we,
    input  logic [bbpp_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [bbpp_pkg::CFG_W-1:0]  i_cfg_data
);
    import bbpp_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd, q_cmd;
    logic push, pop, q_valid, q_full, clearing;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_count <= '0;
            r_cfg.block_size  <= BSZ_W'(1048576);
            r_cfg.min_split   <= MSS_W'(1048576);
            r_cfg.filter_on   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BLOCK_COUNT: r_cfg.block_count <= i_cfg_data[CNT_W-1:0];
                CFG_BLOCK_SIZE:  r_cfg.block_size  <= i_cfg_data[BSZ_W-1:0];
                CFG_MIN_SPLIT:   r_cfg.min_split   <= i_cfg_data[MSS_W-1:0];
                CFG_FILTER_ON:   r_cfg.filter_on   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // a beat is taken when start meets a free slot and the maps are clear
    assign o_busy = q_full | clearing;
    assign push   = i_start & ~o_busy;

    bbpp_front u_front (
        .i_opcode    (i_opcode),
        .i_index     (i_index),
        .i_end_index (i_end_index),
        .i_cfg       (r_cfg),
        .o_cmd       (front_cmd)
    );

    bbpp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    bbpp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd_valid     (q_valid),
        .i_cmd           (q_cmd),
        .o_cmd_pop       (pop),
        .o_clearing      (clearing),
        .o_done          (o_done),
        .o_ok            (o_ok),
        .o_found         (o_found),
        .o_block_index   (o_block_index),
        .o_missing_count (o_missing_count)
    );
endmodule

FILE: hdl/bbpp_checker.sv
// ---------------------------------------------------------------------------
// bbpp_checker
// port-level checks of the piece picker core
// ---------------------------------------------------------------------------
`include "block_bitmap_piece_picker_core_defines.svh"

module bbpp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_busy,
    input logic                       o_done,
    input logic                       o_ok,
    input logic                       o_found,
    input logic [bbpp_pkg::BLK_W-1:0] o_block_index
);
    import bbpp_pkg::*;

    // a bit update never also reports a pick
    `BBPP_ASSERT_IMPL(a_ok_found_excl, o_done, !(o_ok && o_found))
    // no pick means a zero block index
    `BBPP_ASSERT_IMPL(a_idx_zero, o_done && !o_found, o_block_index == '0)
    // reset starts the clearing pass, which holds off new beats
    `BBPP_ASSERT_NEXT(a_reset_busy, !i_rst_n, o_busy)
endmodule

bind block_bitmap_piece_picker_core bbpp_checker u_bbpp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_busy        (o_busy),
    .o_done        (o_done),
    .o_ok          (o_ok),
    .o_found       (o_found),
    .o_block_index (o_block_index)
);

FILE: tb/block_bitmap_piece_picker_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// block_bitmap_piece_picker_core_tb
// self-checking bench: a directed table of bit updates and picks, then
// random phases over several register settings, every result compared with
// its typed-in row or an in-bench model of the four bitmaps and three pick rules
// ---------------------------------------------------------------------------
module block_bitmap_piece_picker_core_tb;
    import bbpp_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED     = 4'd11;   // 11..15 do nothing
    localparam logic [OP_W-1:0] OP_UNUSED_MAX = 4'd15;
    localparam int MAX_SHOWN = 10;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [OP_W-1:0]      i_opcode;
    logic [BLK_W-1:0]     i_index;
    logic [CNT_W-1:0]     i_end_index;
    logic                 o_done;
    logic                 o_ok;
    logic                 o_found;
    logic [BLK_W-1:0]     o_block_index;
    logic [CNT_W-1:0]     o_missing_count;
    logic                 i_cfg_we;
    logic [CIDX_W-1:0]    i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    block_bitmap_piece_picker_core i_dut (.*);

    // one result beat
    typedef struct {
        bit               ok;
        bit               found;
        logic [BLK_W-1:0] blk;
        logic [CNT_W-1:0] miss;
    } t_pick_res;

    // one directed row: either a register write or a command beat
    typedef struct {
        bit                is_cfg;
        logic [CIDX_W-1:0] cidx;
        int unsigned       cdata;
        logic [OP_W-1:0]   op;
        int unsigned       idx;
        int unsigned       endi;
        bit                typed;   // expected result typed in below
        bit                e_ok;
        bit                e_found;
        int unsigned       e_blk;
        int unsigned       e_miss;
    } t_row;

    // model copy of the maps and registers
    bit [MAX_BLOCKS-1:0] have_m, use_m, filt_m, ign_m;
    int unsigned         cnt_reg, bsz_reg, mss_reg;
    bit                  filt_on_reg;

    t_pick_res pending_res[$];
    int        n_errors;
    int        idle_pct;

    // -----------------------------------------------------------------------
    // clock, run limit
    // -----------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("FAIL block_bitmap_piece_picker_core");
        $finish;
    end

    // -----------------------------------------------------------------------
    // model of the picker
    // -----------------------------------------------------------------------
    function automatic int unsigned live_blocks();
        return (cnt_reg > MAX_BLOCKS) ? MAX_BLOCKS : cnt_reg;
    endfunction

    function automatic bit blk_busy(int unsigned i);
        return have_m[i] | use_m[i] | ign_m[i] | (filt_on_reg & ~filt_m[i]);
    endfunction

    // predecessor finished (busy, not being fetched): good spot to continue
    function automatic bit prev_done(int unsigned i);
        return blk_busy(i - 1) && !use_m[i - 1];
    endfunction

    function automatic bit run_worth_split(longint unsigned len);
        return len * longint'(bsz_reg) >= longint'(mss_reg);
    endfunction

    function automatic int unsigned missing_now();
        int unsigned c;
        c = 0;
        for (int unsigned i = 0; i < live_blocks(); i++)
            if (!have_m[i] && (!filt_on_reg || filt_m[i])) c++;
        return c;
    endfunction

    function automatic bit first_free(output int unsigned res);
        res = 0;
        for (int unsigned i = 0; i < live_blocks(); i++)
            if (!have_m[i] && !use_m[i] && (!filt_on_reg || filt_m[i])) begin
                res = i;
                return 1'b1;
            end
        return 1'b0;
    endfunction

    // longest free run, split mid-run behind a block being fetched
    function automatic bit sparse_start(output int unsigned res);
        int unsigned n, bs, be, nxt, s, e;
        n = live_blocks();
        bs = 0; be = 0; nxt = 0; res = 0;
        while (nxt < n) begin
            s = nxt;
            while (s < n && blk_busy(s)) s++;
            if (s >= n) break;
            e = s;
            while (e < n && !blk_busy(e)) e++;
            if (s > 0 && use_m[s - 1]) s = (e - s) / 2 + s;
            if ((e - s) > (be - bs) ||
                ((e - s) == (be - bs) && bs > 0 && s > 0 &&
                 !prev_done(bs) && prev_done(s))) begin
                bs = s;
                be = e;
            end
            nxt = e;
        end
        if (be == bs) return 1'b0;
        if (bs == 0 || prev_done(bs) || run_worth_split(be - bs)) begin
            res = bs;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit inorder_next(int unsigned start, int unsigned stop,
                                        output int unsigned res);
        int unsigned n, last, i, j;
        n = live_blocks();
        res = 0;
        if (start >= n) return 1'b0;
        last = (stop < n) ? stop : n;
        if (!blk_busy(start)) begin
            res = start;
            return 1'b1;
        end
        i = start + 1;
        while (i < last) begin
            if (!blk_busy(i)) begin
                if (prev_done(i)) begin
                    res = i;
                    return 1'b1;
                end
                for (j = i; j < n; j++) begin
                    if (blk_busy(j)) break;
                    if (run_worth_split(longint'(j - i) + 1)) begin
                        res = j;
                        return 1'b1;
                    end
                end
                i = j + 1;
            end else begin
                i++;
            end
        end
        return 1'b0;
    endfunction

    // apply one command beat to the model, return its result
    function automatic t_pick_res apply_cmd(logic [OP_W-1:0] op, int unsigned idx,
                                            int unsigned endi);
        t_pick_res   r;
        int unsigned b;
        int unsigned m;
        r = '{default: 0};
        b = 0;
        if (op <= OP_CLR_IGNORE) begin
            if (idx < live_blocks()) begin
                r.ok = 1'b1;
                case (op)
                    OP_SET_HAVE, OP_CLR_HAVE: begin
                        have_m[idx] = ~op[0];
                    end
                    OP_SET_USE, OP_CLR_USE: begin
                        use_m[idx] = ~op[0];
                    end
                    OP_SET_FILTER, OP_CLR_FILTER: begin
                        filt_m[idx] = ~op[0];
                    end
                    default: begin
                        ign_m[idx] = ~op[0];
                    end
                endcase
            end
        end else if (op == OP_FIRST) begin
            r.found = first_free(b);
        end else if (op == OP_SPARSE) begin
            r.found = sparse_start(b);
        end else if (op == OP_INORDER) begin
            r.found = inorder_next(idx, endi, b);
        end
        r.blk  = r.found ? b[BLK_W-1:0] : '0;
        m      = missing_now();
        r.miss = m[CNT_W-1:0];
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // result checker: every strobe is compared with the oldest expectation
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pick_res want;
        if (i_rst_n && o_done) begin
            if (pending_res.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("result beat with nothing expected: ok=%0d found=%0d blk=%0d miss=%0d",
                             o_ok, o_found, o_block_index, o_missing_count);
            end else begin
                want = pending_res.pop_front();
                if (o_ok !== want.ok || o_found !== want.found ||
                    o_block_index !== want.blk || o_missing_count !== want.miss) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display("mismatch: exp ok=%0d found=%0d blk=%0d miss=%0d, got ok=%0d found=%0d blk=%0d miss=%0d",
                                 want.ok, want.found, want.blk, want.miss,
                                 o_ok, o_found, o_block_index, o_missing_count);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // drivers
    // -----------------------------------------------------------------------
    // worst pass time of one beat at the current block count
    function automatic int unsigned pass_cycles();
        return live_blocks() + live_blocks() / 64 + 16;
    endfunction

    // drain, then write one register (block idle)
    task automatic write_reg(logic [CIDX_W-1:0] cidx, int unsigned val);
        i_start <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (pass_cycles()) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= cidx;
        i_cfg_data  <= val[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (cidx)
            CFG_BLOCK_COUNT: cnt_reg     = val & 32'h1FFF;
            CFG_BLOCK_SIZE:  bsz_reg     = val & 32'h1FF_FFFF;
            CFG_MIN_SPLIT:   mss_reg     = val & 32'h7FFF_FFFF;
            default:         filt_on_reg = val[0];
        endcase
    endtask

    // present one command beat; start stays high on return so back-to-back
    // beats never drop it within one step
    task automatic send_cmd(logic [OP_W-1:0] op, int unsigned idx, int unsigned endi,
                            output t_pick_res got_exp);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_opcode    <= op;
        i_index     <= idx[BLK_W-1:0];
        i_end_index <= endi[CNT_W-1:0];
        do @(posedge i_clk); while (o_busy);
        got_exp = apply_cmd(op, idx, endi);
    endtask

    // -----------------------------------------------------------------------
    // directed table
    // -----------------------------------------------------------------------
    t_row dir_tbl[] = '{
        // reset setting: no blocks, nothing in range, nothing missing
        '{0, 0, 0, OP_SET_HAVE,   0,    0,    1, 0, 0, 0, 0},
        '{0, 0, 0, OP_FIRST,      0,    0,    1, 0, 0, 0, 0},
        '{0, 0, 0, OP_INORDER,    0,    4096, 1, 0, 0, 0, 0},
        '{0, 0, 0, OP_UNUSED_MAX, 4095, 8191, 1, 0, 0, 0, 0},
        '{1, CFG_BLOCK_COUNT, 16, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, OP_SET_HAVE,   15,   0,    1, 1, 0, 0, 15},
        // index at the block count is out of range
        '{0, 0, 0, OP_SET_HAVE,   16,   0,    1, 0, 0, 0, 15},
        '{0, 0, 0, OP_FIRST,      0,    0,    1, 0, 1, 0, 15},
        '{0, 0, 0, OP_SET_USE,    0,    0,    0, 0, 0, 0, 0},
        '{0, 0, 0, OP_SET_IGNORE, 1,    0,    0, 0, 0, 0, 0},
        '{0, 0, 0, OP_SET_HAVE,   3,    0,    0, 0, 0, 0, 0},
        '{0, 0, 0, OP_SPARSE,     0,    0,    0, 0, 0, 0, 0},
        '{0, 0, 0, OP_INORDER,    0,    16,   0, 0, 0, 0, 0},
        // start at the last block, already had, nothing after it
        '{0, 0, 0, OP_INORDER,    15,   0,    1, 0, 0, 0, 14},
        // start beyond the block count
        '{0, 0, 0, OP_INORDER,    4095, 8191, 1, 0, 0, 0, 14},
        '{0, 0, 0, OP_UNUSED,     2,    2,    1, 0, 0, 0, 14},
        '{1, CFG_FILTER_ON, 1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, OP_SET_FILTER, 5,    0,    0, 0, 0, 0, 0},
        '{0, 0, 0, OP_FIRST,      0,    0,    0, 0, 0, 0, 0},
        '{0, 0, 0, OP_SPARSE,     0,    0,    0, 0, 0, 0, 0},
        '{1, CFG_FILTER_ON, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, CFG_BLOCK_SIZE, 1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, CFG_MIN_SPLIT, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, OP_SPARSE,     0,    0,    0, 0, 0, 0, 0},
        '{0, 0, 0, OP_INORDER,    2,    16,   0, 0, 0, 0, 0},
        '{1, CFG_BLOCK_SIZE, 16777216, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, CFG_MIN_SPLIT, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, OP_SET_USE,    4,    0,    0, 0, 0, 0, 0},
        '{0, 0, 0, OP_SPARSE,     0,    0,    0, 0, 0, 0, 0},
        '{0, 0, 0, OP_INORDER,    1,    8,    0, 0, 0, 0, 0},
        '{0, 0, 0, OP_CLR_USE,    0,    0,    0, 0, 0, 0, 0},
        '{0, 0, 0, OP_CLR_IGNORE, 1,    0,    0, 0, 0, 0, 0},
        '{0, 0, 0, OP_CLR_FILTER, 5,    0,    0, 0, 0, 0, 0},
        '{0, 0, 0, OP_CLR_HAVE,   15,   0,    0, 0, 0, 0, 0}
    };

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial begin
        t_pick_res   exp_r;
        int unsigned nb, idx, endi, r, n_items, pick;
        int unsigned e_blk, e_miss, op_raw;
        logic [OP_W-1:0] op;

        have_m = '0; use_m = '0; filt_m = '0; ign_m = '0;
        cnt_reg = 0; bsz_reg = 1048576; mss_reg = 1048576; filt_on_reg = 1'b0;
        n_errors = 0;
        idle_pct = 0;
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_opcode    <= '0;
        i_index     <= '0;
        i_end_index <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // clearing pass keeps busy high
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);

        foreach (dir_tbl[k]) begin
            if (dir_tbl[k].is_cfg) begin
                write_reg(dir_tbl[k].cidx, dir_tbl[k].cdata);
            end else begin
                send_cmd(dir_tbl[k].op, dir_tbl[k].idx, dir_tbl[k].endi, exp_r);
                if (dir_tbl[k].typed) begin
                    e_blk       = dir_tbl[k].e_blk;
                    e_miss      = dir_tbl[k].e_miss;
                    exp_r.ok    = dir_tbl[k].e_ok;
                    exp_r.found = dir_tbl[k].e_found;
                    exp_r.blk   = e_blk[BLK_W-1:0];
                    exp_r.miss  = e_miss[CNT_W-1:0];
                end
                pending_res.push_back(exp_r);
            end
        end

        // random phases; two of them at full and over-range block count
        for (int p = 0; p < 12; p++) begin
            case (p)
                2:       nb = 1;
                5:       nb = MAX_BLOCKS;
                9:       nb = 8191;           // clamped to the map depth
                default: nb = $urandom_range(2, 160);
            endcase
            n_items = (p == 5) ? 8 : (p == 9) ? 6 : 58;
            write_reg(CFG_BLOCK_COUNT, nb);
            r = $urandom_range(3);
            write_reg(CFG_BLOCK_SIZE, (r == 0) ? 1 : (r == 1) ? 16777216
                                                : $urandom_range(1, 8));
            r = $urandom_range(5);
            write_reg(CFG_MIN_SPLIT, (r == 0) ? 0 : (r == 1) ? 32'h7FFF_FFFF
                                    : bsz_reg * $urandom_range(1, 6));
            write_reg(CFG_FILTER_ON, $urandom_range(1));
            idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 64 : 8;
            nb = live_blocks();

            for (int it = 0; it < n_items; it++) begin
                pick = $urandom_range(99);
                if (pick < 55)      op_raw = $urandom_range(OP_SET_HAVE, OP_CLR_IGNORE);
                else if (pick < 95) op_raw = $urandom_range(OP_FIRST, OP_INORDER);
                else                op_raw = $urandom_range(OP_UNUSED, OP_UNUSED_MAX);
                op = op_raw[OP_W-1:0];
                if ($urandom_range(9) < 8 && nb > 0) idx = $urandom_range(0, nb - 1);
                else                                 idx = $urandom_range(0, 4095);
                if ($urandom_range(4) == 0) endi = $urandom_range(0, 8191);
                else                        endi = $urandom_range(idx, nb + 2);
                send_cmd(op, idx, endi, exp_r);
                pending_res.push_back(exp_r);
            end
        end

        i_start <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (pass_cycles()) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS block_bitmap_piece_picker_core");
        end else begin
            $display("FAIL block_bitmap_piece_picker_core");
        end
        $finish;
    end

endmodule
